[src/led_blinker_register_device_defines.svh]
// Assertion macros shared by the blinker RTL.
`ifndef LED_BLINKER_REGISTER_DEVICE_DEFINES_SVH
`define LED_BLINKER_REGISTER_DEVICE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Concurrent check, disabled while reset is asserted
`define LBRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent check that also runs during reset
`define LBRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LBRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBRD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[src/lbrd_pkg.sv]
`default_nettype none

package lbrd_pkg;

  // Default number of LED pins
  localparam int unsigned NumLedsDefault = 16;

  // Register reset values
  localparam logic [7:0] PscReset = 8'h00;
  localparam logic [7:0] PwmReset = 8'h80;
  localparam logic [7:0] LsReset  = 8'h55;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // LED selector codes
  typedef enum logic [1:0] {
    LS_ON     = 2'd0,
    LS_OFF    = 2'd1,
    LS_BLINK0 = 2'd2,
    LS_BLINK1 = 2'd3
  } ls_e;

  // Request payload
  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  reg_index;
    logic [7:0]  write_data;
    logic [15:0] pin_levels;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] led_drive;
    logic        access_error;
  } rsp_t;

endpackage

`default_nettype wire

[src/lbrd_if.sv]
`default_nettype none

// Request channel
interface lbrd_req_if;
  logic              valid;
  logic              ready;
  lbrd_pkg::req_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Response channel
interface lbrd_rsp_if;
  logic              valid;
  logic              ready;
  lbrd_pkg::rsp_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/led_blinker_register_device.sv]
`default_nettype none

// LED blinker register device: byte-wide register map with pin inputs, two
// prescaler/PWM blink generators and 2-bit LED selectors. Each request
// (read, write or tick) yields exactly one response, presented by the single
// response register in the cycle after it is accepted. A new request is
// taken every cycle as long as the response register is empty or is being
// drained in the same cycle, so the sustained rate is one request per cycle.
// led_drive reflects the register state after the request has taken effect.
`include "led_blinker_register_device_defines.svh"

module led_blinker_register_device #(
  parameter int unsigned LED_COUNT = lbrd_pkg::NumLedsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lbrd_req_if.sink         req_i,
  lbrd_rsp_if.source       rsp_o
);

  // Register map layout
  localparam int unsigned InRegs = (LED_COUNT + 7) / 8;
  localparam int unsigned LsRegs = (LED_COUNT + 3) / 4;
  localparam int unsigned RegPsc0 = InRegs;
  localparam int unsigned RegLs0 = InRegs + 4;
  localparam int unsigned RegEnd = RegLs0 + LsRegs;
  localparam logic [15:0] PinMask = 16'((32'd1 << LED_COUNT) - 32'd1);

  logic [7:0] psc_q   [2];
  logic [7:0] psc_d   [2];
  logic [7:0] pwm_q   [2];
  logic [7:0] pwm_d   [2];
  logic [7:0] cnt_q   [2];
  logic [7:0] cnt_d   [2];
  logic [7:0] phase_q [2];
  logic [7:0] phase_d [2];
  logic [7:0] ls_q    [4];
  logic [7:0] ls_d    [4];

  logic           rsp_valid_q;
  lbrd_pkg::rsp_t rsp_q;
  lbrd_pkg::rsp_t rsp_d;
  logic [7:0]     rd_d;
  logic [15:0]    drive_d;
  logic           err_d;

  logic        accept;
  logic [3:0]  idx;
  logic [15:0] pins;
  logic [1:0]  psc_off;
  logic [1:0]  ls_k;
  logic        is_write;
  logic        lit0;
  logic        lit1;

  // Handshake: response register drains or is empty
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign idx      = req_i.data.reg_index;
  assign pins     = req_i.data.pin_levels & PinMask;
  assign psc_off  = 2'(idx - 4'(RegPsc0));
  assign ls_k     = 2'(idx - 4'(RegLs0));
  assign is_write = (req_i.data.operation == lbrd_pkg::OP_WRITE);

  // Register access and tick
  always_comb begin
    psc_d   = psc_q;
    pwm_d   = pwm_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    ls_d    = ls_q;
    rd_d    = 8'h00;
    err_d   = 1'b0;
    if (accept) begin
      case (lbrd_pkg::op_e'(req_i.data.operation))
        lbrd_pkg::OP_READ, lbrd_pkg::OP_WRITE: begin
          if (idx >= 4'(RegEnd)) begin
            err_d = 1'b1;
          end else if (idx < 4'(InRegs)) begin
            // input registers are read only
            if (is_write) begin
              err_d = 1'b1;
            end else begin
              rd_d = idx[0] ? pins[15:8] : pins[7:0];
            end
          end else if (idx < 4'(RegLs0)) begin
            if (is_write) begin
              if (psc_off[0]) pwm_d[psc_off[1]] = req_i.data.write_data;
              else psc_d[psc_off[1]] = req_i.data.write_data;
            end else begin
              rd_d = psc_off[0] ? pwm_q[psc_off[1]] : psc_q[psc_off[1]];
            end
          end else begin
            if (is_write) ls_d[ls_k] = req_i.data.write_data;
            else rd_d = ls_q[ls_k];
          end
        end
        lbrd_pkg::OP_TICK: begin
          for (int g = 0; g < 2; g++) begin
            if (cnt_q[g] >= psc_q[g]) begin
              cnt_d[g]   = 8'h00;
              phase_d[g] = phase_q[g] + 8'd1;
            end else begin
              cnt_d[g] = cnt_q[g] + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Blink outputs from the updated state
  assign lit0 = (phase_d[0] >= pwm_d[0]);
  assign lit1 = (phase_d[1] >= pwm_d[1]);

  // Drive pattern, one selector field per LED
  always_comb begin
    logic [1:0] code;
    code = 2'd0;
    drive_d = 16'h0000;
    for (int i = 0; i < LED_COUNT; i++) begin
      code = ls_d[i / 4][(i % 4) * 2 +: 2];
      case (lbrd_pkg::ls_e'(code))
        lbrd_pkg::LS_ON:     drive_d[i] = 1'b1;
        lbrd_pkg::LS_OFF:    drive_d[i] = 1'b0;
        lbrd_pkg::LS_BLINK0: drive_d[i] = lit0;
        lbrd_pkg::LS_BLINK1: drive_d[i] = lit1;
        default:             drive_d[i] = 1'b0;
      endcase
    end
  end

  // Response assembled in field order
  assign rsp_d = {rd_d, drive_d, err_d};

  // Device registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < 2; g++) begin
        psc_q[g]   <= lbrd_pkg::PscReset;
        pwm_q[g]   <= lbrd_pkg::PwmReset;
        cnt_q[g]   <= 8'h00;
        phase_q[g] <= 8'h00;
      end
      for (int k = 0; k < 4; k++) begin
        ls_q[k] <= lbrd_pkg::LsReset;
      end
    end else begin
      psc_q   <= psc_d;
      pwm_q   <= pwm_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      ls_q    <= ls_d;
    end
  end

  // Response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= req_i.valid;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Checks
  `LBRD_ASSERT(a_tick_clean, clk_i, rst_ni,
    accept && req_i.data.operation == lbrd_pkg::OP_TICK |=>
      rsp_valid_q && !rsp_q.access_error && rsp_q.read_data == 8'h00,
    "tick request gave an error or read data")
  `LBRD_ASSERT(a_input_write_err, clk_i, rst_ni,
    accept && is_write && idx < 4'(InRegs) |=> rsp_valid_q && rsp_q.access_error,
    "write to an input register not flagged")
  `LBRD_ASSERT(a_map_write_ok, clk_i, rst_ni,
    accept && is_write && idx >= 4'(InRegs) && idx < 4'(RegEnd) |=> !rsp_q.access_error,
    "valid register write flagged as error")
  `LBRD_ASSERT(a_phase_step, clk_i, rst_ni,
    accept && req_i.data.operation == lbrd_pkg::OP_TICK && cnt_q[0] >= psc_q[0] |=>
      phase_q[0] == $past(phase_q[0]) + 8'd1 && cnt_q[0] == 8'h00,
    "blink phase 0 did not advance at prescaler wrap")

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;

  // Register map for the default LED count
  localparam int unsigned NumLeds  = lbrd_pkg::NumLedsDefault;
  localparam int unsigned InRegs   = (NumLeds + 7) / 8;
  localparam int unsigned LsRegs   = (NumLeds + 3) / 4;
  localparam logic [3:0]  RegIn0   = 4'd0;
  localparam logic [3:0]  RegIn1   = 4'd1;
  localparam logic [3:0]  RegPsc0  = 4'(InRegs);
  localparam logic [3:0]  RegPwm0  = 4'(InRegs + 1);
  localparam logic [3:0]  RegPsc1  = 4'(InRegs + 2);
  localparam logic [3:0]  RegPwm1  = 4'(InRegs + 3);
  localparam logic [3:0]  RegLs0   = 4'(InRegs + 4);
  localparam logic [3:0]  RegLs1   = 4'(InRegs + 5);
  localparam logic [3:0]  RegLs2   = 4'(InRegs + 6);
  localparam logic [3:0]  RegLs3   = 4'(InRegs + 7);
  localparam logic [3:0]  RegEnd   = 4'(InRegs + 4 + LsRegs);
  localparam logic [3:0]  RegLast  = 4'hF;
  localparam logic [1:0]  OpUnused = 2'd3;
  localparam logic [15:0] PinMask  = 16'((32'd1 << NumLeds) - 32'd1);

  localparam int unsigned RandomRequests = 1700;
  localparam int unsigned HoldOffCycles  = 80;
  localparam int unsigned StallLimit     = 1000;

  typedef struct {
    lbrd_pkg::req_t req;
    bit             typed;
    lbrd_pkg::rsp_t want;
  } directed_row_t;

  logic clk;
  logic rst_n;

  lbrd_req_if req_ch ();
  lbrd_rsp_if rsp_ch ();

  led_blinker_register_device uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // Shadow copy of the device registers and blink generators
  logic [7:0] psc_setting [2];
  logic [7:0] pwm_setting [2];
  logic [7:0] selector    [4];
  logic [7:0] psc_count   [2];
  logic [7:0] blink_phase [2];

  lbrd_pkg::rsp_t awaited_replies [$];
  directed_row_t  directed_rows   [$];
  int unsigned    mismatch_count   = 0;
  int unsigned    stalled_cycles   = 0;
  bit             calm             = 1'b0;
  bit             hold_off_pending = 1'b0;
  bit             hold_off_done    = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the shadow state and return the reply it gives
  function automatic lbrd_pkg::rsp_t device_reply(lbrd_pkg::req_t r);
    lbrd_pkg::rsp_t res;
    logic [15:0]    pins;
    logic [3:0]     off;
    int unsigned    grp;
    int unsigned    i;
    lbrd_pkg::ls_e  code;
    bit             lit;
    res  = '0;
    pins = r.pin_levels & PinMask;
    case (lbrd_pkg::op_e'(r.operation))
      lbrd_pkg::OP_READ, lbrd_pkg::OP_WRITE: begin
        if (r.reg_index >= RegEnd) begin
          res.access_error = 1'b1;
        end else if (r.reg_index < InRegs) begin
          if (r.operation == lbrd_pkg::OP_WRITE) res.access_error = 1'b1;
          else res.read_data = r.reg_index[0] ? pins[15:8] : pins[7:0];
        end else if (r.reg_index < RegLs0) begin
          off = r.reg_index - RegPsc0;
          grp = off[1];
          if (r.operation == lbrd_pkg::OP_WRITE) begin
            if (off[0]) pwm_setting[grp] = r.write_data;
            else psc_setting[grp] = r.write_data;
          end else begin
            res.read_data = off[0] ? pwm_setting[grp] : psc_setting[grp];
          end
        end else begin
          off = r.reg_index - RegLs0;
          if (r.operation == lbrd_pkg::OP_WRITE) selector[off[1:0]] = r.write_data;
          else res.read_data = selector[off[1:0]];
        end
      end
      lbrd_pkg::OP_TICK: begin
        // one phase step every (prescaler + 1) ticks
        for (grp = 0; grp < 2; grp++) begin
          if (psc_count[grp] >= psc_setting[grp]) begin
            psc_count[grp]   = 8'h00;
            blink_phase[grp] = blink_phase[grp] + 8'd1;
          end else begin
            psc_count[grp] = psc_count[grp] + 8'd1;
          end
        end
      end
      default: ;
    endcase
    // drive pattern from the state after the request
    for (i = 0; i < NumLeds; i++) begin
      code = lbrd_pkg::ls_e'(selector[i / 4][2 * (i % 4) +: 2]);
      case (code)
        lbrd_pkg::LS_ON:     lit = 1'b1;
        lbrd_pkg::LS_OFF:    lit = 1'b0;
        lbrd_pkg::LS_BLINK0: lit = blink_phase[0] >= pwm_setting[0];
        default:             lit = blink_phase[1] >= pwm_setting[1];
      endcase
      res.led_drive[i] = lit;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  function automatic void add_row(logic [1:0] op, logic [3:0] idx, logic [7:0] data,
                                  logic [15:0] pins, bit typed = 1'b0,
                                  logic [7:0] rd = '0, logic [15:0] drive = '0,
                                  bit err = 1'b0);
    directed_row_t row;
    row.req.operation     = op;
    row.req.reg_index     = idx;
    row.req.write_data    = data;
    row.req.pin_levels    = pins;
    row.typed             = typed;
    row.want.read_data    = rd;
    row.want.led_drive    = drive;
    row.want.access_error = err;
    directed_rows.push_back(row);
  endfunction

  // Mostly well-formed register traffic with ticks, plus some noise
  function automatic lbrd_pkg::req_t random_request();
    lbrd_pkg::req_t r;
    int unsigned    roll;
    roll         = $urandom_range(99);
    r.operation  = lbrd_pkg::OP_TICK;
    r.reg_index  = 4'($urandom_range(15));
    r.write_data = 8'($urandom_range(255));
    r.pin_levels = 16'($urandom_range(16'hFFFF));
    if (roll >= 45 && roll < 65) begin
      r.operation = lbrd_pkg::OP_WRITE;
      r.reg_index = 4'($urandom_range(RegEnd - 1, RegPsc0));
      // short prescalers keep the phase moving
      if (r.reg_index == RegPsc0 || r.reg_index == RegPsc1) begin
        if ($urandom_range(9) < 8) r.write_data = 8'($urandom_range(3));
      end else if (r.reg_index == RegPwm0 || r.reg_index == RegPwm1) begin
        case ($urandom_range(3))
          0: r.write_data = 8'h00;
          1: r.write_data = 8'hFF;
          default: ;
        endcase
      end
    end else if (roll >= 65 && roll < 90) begin
      r.operation = lbrd_pkg::OP_READ;
      r.reg_index = 4'($urandom_range(RegEnd - 1));
    end else if (roll >= 90) begin
      r.operation = 2'($urandom_range(3));
    end
    return r;
  endfunction

  // Offer one request, with random idle cycles first
  task automatic offer_request(lbrd_pkg::req_t r, bit typed, lbrd_pkg::rsp_t want);
    lbrd_pkg::rsp_t predicted;
    while (!calm && $urandom_range(99) < 7) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    predicted = device_reply(r);
    awaited_replies.push_back(typed ? want : predicted);
  endtask

  // Response side: random back-pressure and one long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending && !hold_off_done) begin
        hold_off_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      rsp_ch.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // Reply checker and watchdog
  always @(posedge clk) begin
    lbrd_pkg::rsp_t want;
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected reply, led_drive", rsp_ch.data.led_drive, 0);
      end else begin
        want = awaited_replies.pop_front();
        if (rsp_ch.data.read_data !== want.read_data)
          report_mismatch("read_data", rsp_ch.data.read_data, want.read_data);
        if (rsp_ch.data.led_drive !== want.led_drive)
          report_mismatch("led_drive", rsp_ch.data.led_drive, want.led_drive);
        if (rsp_ch.data.access_error !== want.access_error)
          report_mismatch("access_error", rsp_ch.data.access_error, want.access_error);
      end
    end
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    lbrd_pkg::rsp_t no_reply;
    lbrd_pkg::req_t r;
    int unsigned    n;
    no_reply     = '0;
    rst_n        <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    for (n = 0; n < 2; n++) begin
      psc_setting[n] = lbrd_pkg::PscReset;
      pwm_setting[n] = lbrd_pkg::PwmReset;
      psc_count[n]   = 8'h00;
      blink_phase[n] = 8'h00;
    end
    for (n = 0; n < 4; n++) selector[n] = lbrd_pkg::LsReset;

    // reset values, pin inputs, bad accesses, then blink set-up
    add_row(lbrd_pkg::OP_READ,  RegLs0,  8'h00, 16'h0000, 1, 8'h55, 16'h0000, 0);
    add_row(lbrd_pkg::OP_READ,  RegLs3,  8'hFF, 16'hFFFF, 1, 8'h55, 16'h0000, 0);
    add_row(lbrd_pkg::OP_READ,  RegPsc0, 8'h00, 16'h0000, 1, 8'h00, 16'h0000, 0);
    add_row(lbrd_pkg::OP_READ,  RegPwm1, 8'h00, 16'h0000, 1, 8'h80, 16'h0000, 0);
    add_row(lbrd_pkg::OP_READ,  RegIn0,  8'h00, 16'hFFFF, 1, 8'hFF, 16'h0000, 0);
    add_row(lbrd_pkg::OP_READ,  RegIn1,  8'hFF, 16'h0000, 1, 8'h00, 16'h0000, 0);
    add_row(lbrd_pkg::OP_READ,  RegIn1,  8'h00, 16'hA5C3, 1, 8'hA5, 16'h0000, 0);
    add_row(lbrd_pkg::OP_WRITE, RegIn0,  8'hFF, 16'hFFFF, 1, 8'h00, 16'h0000, 1);
    add_row(lbrd_pkg::OP_WRITE, RegIn1,  8'h00, 16'h0000, 1, 8'h00, 16'h0000, 1);
    add_row(lbrd_pkg::OP_READ,  RegEnd,  8'h00, 16'hFFFF, 1, 8'h00, 16'h0000, 1);
    add_row(lbrd_pkg::OP_WRITE, RegLast, 8'hFF, 16'h0000, 1, 8'h00, 16'h0000, 1);
    add_row(lbrd_pkg::OP_READ,  RegLast, 8'h00, 16'h0000, 1, 8'h00, 16'h0000, 1);
    add_row(OpUnused,           RegLs0,  8'h00, 16'hFFFF, 1, 8'h00, 16'h0000, 0);
    add_row(lbrd_pkg::OP_READ,  RegLs0,  8'h00, 16'h0000, 1, 8'h55, 16'h0000, 0);
    add_row(lbrd_pkg::OP_WRITE, RegLs0,  8'h00, 16'h0000, 1, 8'h00, 16'h000F, 0);
    add_row(lbrd_pkg::OP_WRITE, RegPwm1, 8'h00, 16'h0000);
    add_row(lbrd_pkg::OP_WRITE, RegLs3,  8'hFF, 16'h0000);
    add_row(lbrd_pkg::OP_WRITE, RegPsc0, 8'hFF, 16'h0000);
    add_row(lbrd_pkg::OP_WRITE, RegPwm0, 8'hFF, 16'h0000);
    add_row(lbrd_pkg::OP_WRITE, RegLs1,  8'hAA, 16'h0000);
    add_row(lbrd_pkg::OP_TICK,  RegLs0,  8'h00, 16'h0000);
    add_row(lbrd_pkg::OP_TICK,  RegLast, 8'hFF, 16'hFFFF);
    add_row(lbrd_pkg::OP_WRITE, RegLs2,  8'h00, 16'h0000);
    add_row(lbrd_pkg::OP_WRITE, RegPsc1, 8'h01, 16'h0000);
    add_row(lbrd_pkg::OP_READ,  RegPsc0, 8'h00, 16'h0000);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    for (n = 0; n < RandomRequests; n++) begin
      calm = (n >= 300 && n < 600);
      if (n == 900) hold_off_pending = 1'b1;
      // let every outstanding reply drain before carrying on
      if (n == 1300) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (awaited_replies.size() != 0);
      end
      r = random_request();
      offer_request(r, 1'b0, no_reply);
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
